[rtl/core/qeec_pkg.sv]
// ----------------------------------------------------------------------------
// Quadrature encoder emulator package
// Shared widths, register indexes and the types passed between the front
// end, the item queue and the counting back end.
// ----------------------------------------------------------------------------
`default_nettype none

package qeec_pkg;

  // Angle resolution: one revolution is 2**AngleBits units.
  localparam int AngleBits  = 16;
  // Width of the internal position counter.
  localparam int CountBits  = 32;
  // Width of the position field on the output port.
  localparam int PosOutBits = 32;
  // Width used for angle sums and compares, wide enough for any AngleBits up to 33.
  localparam int CalcW      = 34;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;

  localparam logic [CfgIdxW-1:0] RegZeroOffset  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPulsesPerRev = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBPhaseOffset = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIndexEnable = 3'd3;
  localparam logic [CfgIdxW-1:0] RegIndexWidth  = 3'd4;

  // Configuration as seen by the front end.
  typedef struct packed {
    logic [15:0] zero_offset;
    logic [15:0] pulses_per_rev;
    logic [15:0] b_phase_offset;
    logic        index_enable;
    logic [15:0] win_half;
  } cfg_t;

  // One classified item: new channel levels and the index flag.
  typedef struct packed {
    logic chan_a;
    logic chan_b;
    logic index_out;
  } item_t;

endpackage

`default_nettype wire

[rtl/core/qeec_front.sv]
// ----------------------------------------------------------------------------
// Quadrature encoder emulator front end
// Takes a rotor angle, removes the zero offset and derives the A/B levels and
// the index flag, then pushes the classified item into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module qeec_front import qeec_pkg::*; (
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [15:0] rotor_angle_i,
  input  wire cfg_t        cfg_i,
  input  wire logic        queue_full_i,
  output      logic        push_o,
  output      item_t       item_o
);

  logic [CalcW-1:0]     diff;
  logic [CalcW-1:0]     sum_b;
  logic [AngleBits-1:0] angle;
  logic [AngleBits-1:0] angle_b;
  logic [AngleBits-1:0] ppr;
  logic [AngleBits-1:0] phase_a;
  logic [AngleBits-1:0] phase_b;
  logic [CalcW-1:0]     win_hi;
  logic [CalcW-1:0]     full_rev;
  logic                 in_window;

  assign diff    = CalcW'(rotor_angle_i) - CalcW'(cfg_i.zero_offset);
  assign angle   = diff[AngleBits-1:0];
  assign sum_b   = CalcW'(angle) + CalcW'(cfg_i.b_phase_offset);
  assign angle_b = sum_b[AngleBits-1:0];

  // Only the fractional part of the phase matters, so the products are kept
  // at the angle width.
  assign ppr     = AngleBits'(cfg_i.pulses_per_rev);
  assign phase_a = angle * ppr;
  assign phase_b = angle_b * ppr;

  assign win_hi    = CalcW'(angle) + CalcW'(cfg_i.win_half);
  assign full_rev  = CalcW'(1) << AngleBits;
  assign in_window = (CalcW'(angle) < CalcW'(cfg_i.win_half)) || (win_hi > full_rev);

  assign in_stall_o       = queue_full_i;
  assign push_o           = in_valid_i && !queue_full_i;
  assign item_o.chan_a    = !phase_a[AngleBits-1];
  assign item_o.chan_b    = !phase_b[AngleBits-1];
  assign item_o.index_out = cfg_i.index_enable && in_window;

endmodule

`default_nettype wire

[rtl/core/qeec_queue.sv]
// ----------------------------------------------------------------------------
// Quadrature encoder emulator item queue
// A small FIFO that decouples the front end from the counting back end.
// ----------------------------------------------------------------------------
`default_nettype none

module qeec_queue import qeec_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output      logic  full_o,
  input  wire logic  pop_i,
  output      logic  valid_o,
  output      item_t item_o
);

  item_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntW'(QueueDepth))
    else $error("queue count above depth");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
    else $error("push without pop did not grow the queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == QueueCntW'(QueueDepth)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

[rtl/core/qeec_back.sv]
// ----------------------------------------------------------------------------
// Quadrature encoder emulator back end
// Runs the 4x decoder against the stored channel levels, keeps the position
// count and holds the result item in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qeec_back import qeec_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  item_valid_i,
  input  wire item_t                 item_i,
  output      logic                  pop_o,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic                  chan_a_o,
  output      logic                  chan_b_o,
  output      logic                  index_out_o,
  output      logic [PosOutBits-1:0] position_count_o
);

  logic [CountBits-1:0] position_q, position_d;
  logic [CountBits-1:0] step_a;
  logic [CountBits-1:0] step_b;
  logic                 last_a_q;
  logic                 last_b_q;
  logic                 out_valid_q, out_valid_d;
  item_t                out_item_q;
  logic [63:0]          pos_ext;

  assign pop_o = item_valid_i && (!out_valid_q || !out_stall_i);

  // Each changed channel moves the count by one; opposite moves cancel.
  always_comb begin
    step_a = '0;
    step_b = '0;
    if (item_i.chan_a != last_a_q) begin
      step_a = (item_i.chan_a == item_i.chan_b) ? CountBits'(1) : '1;
    end
    if (item_i.chan_b != last_b_q) begin
      step_b = (item_i.chan_a != item_i.chan_b) ? CountBits'(1) : '1;
    end
    position_d = position_q + step_a + step_b;
  end

  assign out_valid_d = pop_o || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q  <= '0;
      last_a_q    <= 1'b0;
      last_b_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        position_q <= position_d;
        last_a_q   <= item_i.chan_a;
        last_b_q   <= item_i.chan_b;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_item_q <= item_i;
    end
  end

  assign pos_ext          = 64'(position_q);
  assign out_valid_o      = out_valid_q;
  assign chan_a_o         = out_item_q.chan_a;
  assign chan_b_o         = out_item_q.chan_b;
  assign index_out_o      = out_item_q.index_out;
  assign position_count_o = pos_ext[PosOutBits-1:0];

`ifndef SYNTHESIS
  a_hold_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_o |=> $stable(position_q))
    else $error("position moved without an item");

  a_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && item_i.chan_a == last_a_q && item_i.chan_b == last_b_q
    |=> $stable(position_q))
    else $error("position moved with unchanged channels");

  a_levels_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> last_a_q == chan_a_o && last_b_q == chan_b_o && out_valid_q)
    else $error("stored levels differ from the shown result");
`endif

endmodule

`default_nettype wire

[rtl/core/quadrature_encoder_emulator_counter_top.sv]
// ----------------------------------------------------------------------------
// Quadrature encoder emulator with 4x counter, top level
// Turns a stream of rotor angles into synthesized A/B/index levels and a
// signed 4x quadrature position count.
// ----------------------------------------------------------------------------
//
//  channel   signals                                  direction
//  -------   ---------------------------------------  ---------
//  input     in_valid_i, in_stall_o, rotor_angle_i     in
//  output    out_valid_o, out_stall_i, chan_a_o,       out
//            chan_b_o, index_out_o, position_count_o
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,    in
//            cfg_data_i
//
// The block takes one item per clock while the queue is not full. An accepted
// item is written into a four-entry queue and from there into the output
// register, where its result is shown; the rate is set by the decoder update
// of the position counter, made once for each item.
// Reset clears the count and stored channel levels to zero, empties the queue
// and loads the register defaults. A stalled output holds its item while the
// queue keeps taking input; the input stalls only once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_encoder_emulator_counter_top import qeec_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Input item channel.
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [15:0]           rotor_angle_i,
  // Result item channel.
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic                  chan_a_o,
  output      logic                  chan_b_o,
  output      logic                  index_out_o,
  output      logic [PosOutBits-1:0] position_count_o,
  // Register write channel.
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [CfgDataW-1:0]   cfg_data_i
);

  cfg_t  cfg_q;
  logic  queue_full;
  logic  push;
  item_t front_item;
  logic  pop;
  logic  queue_valid;
  item_t queue_item;

  // Always writable; user must reconfigure block only while idle (unchecked).
  assign cfg_ready_o = 1'b1;

  // Register file. Each register keeps only its own width of the data, and
  // writes to indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_offset    <= 16'd0;
      cfg_q.pulses_per_rev <= 16'd1024;
      cfg_q.b_phase_offset <= 16'd16384;
      cfg_q.index_enable   <= 1'b1;
      cfg_q.win_half       <= 16'd32;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegZeroOffset:   cfg_q.zero_offset    <= cfg_data_i;
        RegPulsesPerRev: cfg_q.pulses_per_rev <= cfg_data_i;
        RegBPhaseOffset: cfg_q.b_phase_offset <= cfg_data_i;
        RegIndexEnable:  cfg_q.index_enable   <= cfg_data_i[0];
        RegIndexWidth:   cfg_q.win_half       <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The front end computes the channel levels and the index window from the
  // angle in the cycle the item arrives.
  qeec_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rotor_angle_i (rotor_angle_i),
    .cfg_i         (cfg_q),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .item_o        (front_item)
  );

  // Classified items wait here so the two halves can stall independently.
  qeec_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  // The back end applies items strictly in order, so the decoder always sees
  // the previous item's channel levels.
  qeec_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (queue_valid),
    .item_i           (queue_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .chan_a_o         (chan_a_o),
    .chan_b_o         (chan_b_o),
    .index_out_o      (index_out_o),
    .position_count_o (position_count_o)
  );

endmodule

`default_nettype wire
